@@ src/dilp_pkg.sv @@
package dilp_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0]  CHAR_ZERO  = 8'h30;
  localparam logic [7:0]  CHAR_NINE  = 8'h39;
  localparam logic [7:0]  CHAR_PLUS  = 8'h2B;
  localparam logic [7:0]  CHAR_MINUS = 8'h2D;
  localparam logic [7:0]  CHAR_NUL   = 8'h00;

  localparam logic [31:0] MAG_CAP    = 32'h8000_0000;
  localparam logic [31:0] INT32_MAX  = 32'h7FFF_FFFF;
  localparam logic [15:0] MAX_NUMBERS_RESET = 16'hFFFF;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] number_value;
    logic [15:0]        number_index;
    logic               done_res;
    logic [15:0]        total_count;
  } out_word_t;

  typedef enum logic [2:0] {
    TK_DIGIT,
    TK_PLUS,
    TK_MINUS,
    TK_OTHER,
    TK_TERM
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t  kind;
    logic [3:0] digit;
  } token_t;

endpackage

@@ src/dilp_front.sv @@
module dilp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  dilp_pkg::in_word_t in_word,
  output logic              tok_valid,
  input  logic              tok_pop,
  output dilp_pkg::token_t  tok
);
  import dilp_pkg::*;

  token_t                  queue_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]     wr_ptr_r;
  logic [QUEUE_AW-1:0]     wr_ptr_nxt;
  logic [QUEUE_AW-1:0]     rd_ptr_r;
  logic [QUEUE_AW-1:0]     rd_ptr_nxt;
  logic [QUEUE_CW-1:0]     count_r;
  logic [QUEUE_CW-1:0]     count_nxt;
  logic                    push;
  logic                    pop;
  token_t                  cls;

  always_comb begin
    cls.digit = in_word.text_byte[3:0];
    if (in_word.end_of_text || in_word.text_byte == CHAR_NUL) begin
      cls.kind = TK_TERM;
    end else if (in_word.text_byte inside {[CHAR_ZERO:CHAR_NINE]}) begin
      cls.kind = TK_DIGIT;
    end else if (in_word.text_byte == CHAR_PLUS) begin
      cls.kind = TK_PLUS;
    end else if (in_word.text_byte == CHAR_MINUS) begin
      cls.kind = TK_MINUS;
    end else begin
      cls.kind = TK_OTHER;
    end
  end

  assign in_stall  = (count_r == QUEUE_CW'(QUEUE_DEPTH));
  assign tok_valid = (count_r != '0);
  assign tok       = queue_r[rd_ptr_r];
  assign push      = in_valid && !in_stall;
  assign pop       = tok_valid && tok_pop;

  always_comb begin
    wr_ptr_nxt = push ? QUEUE_AW'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? QUEUE_AW'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = QUEUE_CW'(count_r + 1'b1);
    end else if (pop && !push) begin
      count_nxt = QUEUE_CW'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue_r[wr_ptr_r] <= cls;
    end
  end

endmodule

@@ src/dilp_back.sv @@
module dilp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data,
  input  logic               tok_valid,
  output logic               tok_pop,
  input  dilp_pkg::token_t   tok,
  output logic               out_valid,
  input  logic               out_stall,
  output dilp_pkg::out_word_t out_word
);
  import dilp_pkg::*;

  typedef enum logic [1:0] {
    SCAN_IDLE,
    SCAN_SIGN,
    SCAN_NUM
  } scan_t;

  scan_t       scan_r, scan_nxt, base_scan;
  logic        neg_r, neg_nxt, base_neg;
  logic [31:0] mag_r, mag_nxt;
  logic [15:0] found_r, found_nxt;
  logic [15:0] max_r;
  logic        out_valid_r, out_valid_nxt;
  out_word_t   out_word_r, out_word_nxt;
  logic        pend_valid_r, pend_valid_nxt;
  out_word_t   pend_word_r, pend_word_nxt;

  logic        out_free;
  logic        emit;
  logic [34:0] prod;
  logic [31:0] num_val;
  logic [1:0]  n_res;
  out_word_t   res0, res1, num_res;

  assign out_free  = !out_valid_r || !out_stall;
  assign tok_pop   = tok_valid && out_free && !pend_valid_r;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  assign prod = ({3'b000, mag_r} << 3) + ({3'b000, mag_r} << 1) + 35'(tok.digit);

  always_comb begin
    if (neg_r) begin
      num_val = 32'd0 - mag_r;
    end else begin
      num_val = mag_r[31] ? INT32_MAX : mag_r;
    end
    num_res.number_value = num_val;
    num_res.number_index = found_r;
    num_res.done_res     = 1'b0;
    num_res.total_count  = '0;
  end

  always_comb begin
    scan_nxt  = scan_r;
    neg_nxt   = neg_r;
    mag_nxt   = mag_r;
    found_nxt = found_r;
    n_res     = 2'd0;
    res0      = num_res;
    res1      = '0;
    emit      = 1'b0;
    base_scan = scan_r;
    base_neg  = neg_r;
    if (tok_pop) begin
      case (tok.kind)
        TK_TERM: begin
          scan_nxt  = SCAN_IDLE;
          neg_nxt   = 1'b0;
          mag_nxt   = '0;
          found_nxt = '0;
          if (scan_r == SCAN_NUM) begin
            n_res             = 2'd2;
            res1.done_res     = 1'b1;
            res1.total_count  = 16'(found_r + 1'b1);
          end else begin
            n_res             = 2'd1;
            res0              = '0;
            res0.done_res     = 1'b1;
            res0.total_count  = found_r;
          end
        end
        default: begin
          if (scan_r == SCAN_NUM && tok.kind == TK_DIGIT) begin
            mag_nxt = (prod > {3'b000, MAG_CAP}) ? MAG_CAP : prod[31:0];
          end else begin
            emit = (scan_r == SCAN_NUM);
            if (emit) begin
              n_res     = 2'd1;
              found_nxt = 16'(found_r + 1'b1);
              base_scan = SCAN_IDLE;
              base_neg  = 1'b0;
              mag_nxt   = '0;
            end
            if (found_nxt >= max_r) begin
              scan_nxt = SCAN_IDLE;
              neg_nxt  = 1'b0;
            end else begin
              case (tok.kind)
                TK_DIGIT: begin
                  neg_nxt  = (base_scan == SCAN_SIGN) ? base_neg : 1'b0;
                  scan_nxt = SCAN_NUM;
                  mag_nxt  = 32'(tok.digit);
                end
                TK_PLUS: begin
                  scan_nxt = SCAN_SIGN;
                  neg_nxt  = 1'b0;
                end
                TK_MINUS: begin
                  scan_nxt = SCAN_SIGN;
                  neg_nxt  = 1'b1;
                end
                default: begin
                  scan_nxt = SCAN_IDLE;
                  neg_nxt  = 1'b0;
                end
              endcase
            end
          end
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt  = out_valid_r && out_stall;
    out_word_nxt   = out_word_r;
    pend_valid_nxt = pend_valid_r;
    pend_word_nxt  = pend_word_r;
    if (out_free) begin
      if (pend_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_word_nxt   = pend_word_r;
        pend_valid_nxt = 1'b0;
      end else if (n_res != 2'd0) begin
        out_valid_nxt  = 1'b1;
        out_word_nxt   = res0;
        pend_valid_nxt = (n_res == 2'd2);
        pend_word_nxt  = res1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r       <= SCAN_IDLE;
      neg_r        <= 1'b0;
      mag_r        <= '0;
      found_r      <= '0;
      max_r        <= MAX_NUMBERS_RESET;
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      scan_r       <= scan_nxt;
      neg_r        <= neg_nxt;
      mag_r        <= mag_nxt;
      found_r      <= found_nxt;
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
      if (cfg_wr_en) begin
        max_r <= cfg_wr_data;
      end
    end
    out_word_r  <= out_word_nxt;
    pend_word_r <= pend_word_nxt;
  end

endmodule

@@ src/decimal_int32_list_parser_unit.sv @@
// Channel  Direction  Handshake              Word
// in_      input      in_valid / in_stall    in_word  (text_byte, end_of_text)
// out_     output     out_valid / out_stall  out_word (number_value, number_index,
//                                                      done_res, total_count)
// cfg_     input      cfg_wr_en              cfg_wr_data (max_numbers)
//
// One byte per cycle while in_stall is low; a byte is classified into a 4-entry
// token queue and the parser consumes one token per cycle when the output register
// is free and no second word is pending. A terminator that closes an open number
// gives two words and holds the parser until the second is passed on; the queue absorbs
// it. Reset (rst_n low, synchronous) empties the queue and output, sets max_numbers
// to 65535. out_stall holds the output word; the queue fills, then in_stall rises.
module decimal_int32_list_parser_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  dilp_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output dilp_pkg::out_word_t out_word,
  input  logic                cfg_wr_en,
  input  logic [15:0]         cfg_wr_data
);
  import dilp_pkg::*;

  logic   tok_valid;
  logic   tok_pop;
  token_t tok;

  dilp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .tok_valid (tok_valid),
    .tok_pop   (tok_pop),
    .tok       (tok)
  );

  dilp_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .tok_valid   (tok_valid),
    .tok_pop     (tok_pop),
    .tok         (tok),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_word    (out_word)
  );

endmodule

@@ dv/decimal_int32_list_parser_unit_test.sv @@
module decimal_int32_list_parser_unit_test;
  import dilp_pkg::*;

  localparam int LIMIT_CYCLES  = 200000;
  localparam int PHASES        = 8;
  localparam int PHASE_BYTES   = 190;
  localparam int SETTLE_CYCLES = 4;
  localparam int REPORT_CAP    = 10;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;

  typedef enum logic [1:0] {
    SCAN_IDLE,
    SCAN_SIGN,
    SCAN_NUM
  } scan_mode_t;

  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  logic        in_stall;
  in_word_t    in_word     = '0;
  logic        out_valid;
  logic        out_stall   = 1'b0;
  out_word_t   out_word;
  logic        cfg_wr_en   = 1'b0;
  logic [15:0] cfg_wr_data = '0;

  in_word_t  text_bytes[$];
  out_word_t parsed_list[$];

  int send_gap_pct   = 0;
  int recv_stall_pct = 0;
  int fail_count     = 0;
  int cycle_count    = 0;

  logic [15:0] number_limit  = MAX_NUMBERS_RESET;
  scan_mode_t  scan_mode     = SCAN_IDLE;
  logic        negative_sign = 1'b0;
  logic [31:0] magnitude     = '0;
  logic [15:0] numbers_found = '0;

  decimal_int32_list_parser_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_word     (in_word),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_word    (out_word),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #5 clk = ~clk;

  task automatic close_number();
    out_word_t w;
    w = '0;
    if (negative_sign) begin
      w.number_value = 32'd0 - magnitude;
    end else begin
      w.number_value = (magnitude > INT32_MAX) ? INT32_MAX : magnitude;
    end
    w.number_index = numbers_found;
    parsed_list.push_back(w);
    numbers_found = numbers_found + 16'd1;
    scan_mode     = SCAN_IDLE;
    negative_sign = 1'b0;
    magnitude     = '0;
  endtask

  task automatic parse_byte(input in_word_t w);
    logic        is_digit;
    logic [35:0] grown;
    out_word_t   done_word;
    is_digit = (w.text_byte >= CHAR_ZERO) && (w.text_byte <= CHAR_NINE);
    if (w.end_of_text || w.text_byte == CHAR_NUL) begin
      if (scan_mode == SCAN_NUM) close_number();
      done_word             = '0;
      done_word.done_res    = 1'b1;
      done_word.total_count = numbers_found;
      parsed_list.push_back(done_word);
      scan_mode     = SCAN_IDLE;
      negative_sign = 1'b0;
      magnitude     = '0;
      numbers_found = '0;
    end else if (scan_mode == SCAN_NUM && is_digit) begin
      grown = {4'd0, magnitude} * 36'd10 + {28'd0, w.text_byte - CHAR_ZERO};
      magnitude = (grown > {4'd0, MAG_CAP}) ? MAG_CAP : grown[31:0];
    end else begin
      if (scan_mode == SCAN_NUM) close_number();
      if (numbers_found >= number_limit) begin
        scan_mode     = SCAN_IDLE;
        negative_sign = 1'b0;
      end else if (is_digit) begin
        if (scan_mode != SCAN_SIGN) negative_sign = 1'b0;
        scan_mode = SCAN_NUM;
        magnitude = {24'd0, w.text_byte - CHAR_ZERO};
      end else if (w.text_byte == CHAR_PLUS || w.text_byte == CHAR_MINUS) begin
        scan_mode     = SCAN_SIGN;
        negative_sign = (w.text_byte == CHAR_MINUS);
      end else begin
        scan_mode     = SCAN_IDLE;
        negative_sign = 1'b0;
      end
    end
  endtask

  task automatic push_char(input logic [7:0] c);
    in_word_t w;
    w.text_byte   = c;
    w.end_of_text = 1'b0;
    text_bytes.push_back(w);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i]);
  endtask

  task automatic push_end(input logic eot, input logic [7:0] c);
    in_word_t w;
    w.text_byte   = eot ? c : CHAR_NUL;
    w.end_of_text = eot;
    text_bytes.push_back(w);
  endtask

  task automatic push_sign();
    push_char($urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS);
  endtask

  task automatic push_gap();
    case ($urandom_range(0, 3))
      0: push_char(CHAR_SPACE);
      1: push_char(CHAR_TAB);
      2: push_char(CHAR_COMMA);
      default: repeat ($urandom_range(2, 4)) push_char(CHAR_SPACE);
    endcase
  endtask

  task automatic push_number();
    string boundary_values[4];
    int    pick;
    boundary_values = '{"2147483647", "2147483648", "2147483649", "99999999999"};
    case ($urandom_range(0, 5))
      3: push_char(CHAR_PLUS);
      4: push_char(CHAR_MINUS);
      5: begin
        push_sign();
        push_sign();
      end
      default: ;
    endcase
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      push_text(boundary_values[$urandom_range(0, 3)]);
    end else begin
      repeat ((pick < 18) ? $urandom_range(10, 12) : $urandom_range(1, 4))
        push_char(CHAR_ZERO + 8'($urandom_range(0, 9)));
    end
  endtask

  task automatic queue_string();
    int pick;
    repeat ($urandom_range(0, 8)) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        push_number();
        if ($urandom_range(0, 9) < 7) push_gap();
      end else if (pick < 75) begin
        push_gap();
      end else if (pick < 85) begin
        push_sign();
        push_gap();
      end else begin
        push_char(8'($urandom_range(1, 255)));
      end
    end
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      push_end(1'b1, 8'($urandom_range(0, 255)));
    end else if (pick < 90) begin
      push_end(1'b0, CHAR_NUL);
    end
  endtask

  // feed one text byte per accepted word; hold the word while stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) parse_byte(in_word);
      if (!in_valid || !in_stall) begin
        if (text_bytes.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
          in_word  <= text_bytes.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (parsed_list.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_CAP)
            $display("unexpected word: value %0d index %0d done %0b count %0d",
                     out_word.number_value, out_word.number_index,
                     out_word.done_res, out_word.total_count);
        end else begin
          want = parsed_list.pop_front();
          if (out_word.number_value !== want.number_value ||
              out_word.number_index !== want.number_index ||
              out_word.done_res !== want.done_res ||
              out_word.total_count !== want.total_count) begin
            fail_count++;
            if (fail_count <= REPORT_CAP)
              $display({"mismatch: expected value %0d index %0d done %0b count %0d,",
                        " got value %0d index %0d done %0b count %0d"},
                       want.number_value, want.number_index, want.done_res,
                       want.total_count, out_word.number_value, out_word.number_index,
                       out_word.done_res, out_word.total_count);
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    logic [15:0] limit_plan[PHASES];
    int          target;
    limit_plan = '{MAX_NUMBERS_RESET, 16'd0, 16'd1, 16'd3, 16'd2, 16'd65534, 16'd4,
                   MAX_NUMBERS_RESET};
    limit_plan[6] = 16'($urandom_range(0, 6));
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    for (int p = 0; p < PHASES; p++) begin
      while (text_bytes.size() != 0 || in_valid || parsed_list.size() != 0) @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);
      send_gap_pct   = (p < 3) ? 12 : (p < 6) ? 49 : 0;
      recv_stall_pct = (p < 3) ? 49 : (p < 6) ? 12 : 0;
      cfg_wr_en    <= 1'b1;
      cfg_wr_data  <= limit_plan[p];
      number_limit  = limit_plan[p];
      @(posedge clk);
      cfg_wr_en <= 1'b0;
      if (p == 0) begin
        // min int32, tab, double sign, sign then junk, terminator flag over a digit
        push_text("-2147483648");
        push_char(CHAR_TAB);
        push_text("+-7 +");
        push_char(8'hFF);
        push_char("9");
        push_end(1'b1, "5");
        push_end(1'b0, CHAR_NUL);
      end
      target = text_bytes.size() + PHASE_BYTES;
      while (text_bytes.size() < target) queue_string();
    end
    while (text_bytes.size() != 0 || in_valid || parsed_list.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && parsed_list.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/dilp_pkg.sv
src/dilp_front.sv
src/dilp_back.sv
src/decimal_int32_list_parser_unit.sv
dv/decimal_int32_list_parser_unit_test.sv
